// File: sv/udv_pkg.sv
// Shared widths, config register indices and inter-stage payload types.
package udv_pkg;

  localparam int unsigned VtxW   = 24;  // vertex field width
  localparam int unsigned CfgW   = 31;  // config register width
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DirW   = 16;  // Q1.15 component
  localparam int unsigned DiffW  = 34;  // vertex minus source point
  localparam int unsigned MagW   = 32;  // |d|
  localparam int unsigned SqW    = 64;  // d^2 and sum of squares
  localparam int unsigned QuoW   = 33;  // floor(2^32 * d^2 / S)
  localparam int unsigned RootW  = 17;  // isqrt of the quotient
  localparam int unsigned SqrtRemW = 19;
  localparam int unsigned DivStages  = QuoW;
  localparam int unsigned SqrtStages = RootW;
  localparam logic [DirW-1:0] DirMaxPos = 16'h7fff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_X   = 3'd0,
    CFG_SOURCE_Y   = 3'd1,
    CFG_SOURCE_Z   = 3'd2,
    CFG_DETECTOR_X = 3'd3,
    CFG_DETECTOR_Y = 3'd4,
    CFG_DETECTOR_Z = 3'd5
  } udv_cfg_idx_e;

  typedef struct packed {
    logic [2:0][CfgW-1:0] src;
    logic [2:0][CfgW-1:0] det;
  } udv_cfg_t;

  typedef struct packed {
    logic [SqW-1:0]       s;
    logic [2:0][SqW-1:0]  sq;
    logic [2:0]           neg;
    logic                 zero;
  } udv_sum_t;

  typedef struct packed {
    logic [2:0][QuoW-1:0] quo;
    logic [2:0]           neg;
    logic                 zero;
  } udv_quo_t;

  typedef struct packed {
    logic [2:0][RootW-1:0] root;
    logic [2:0]            neg;
    logic                  zero;
  } udv_root_t;

endpackage

// File: sv/udv_if.sv
// Channel interfaces: vertex input, direction output and config writes.
interface udv_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [udv_pkg::VtxW-1:0] vertex_x;
  logic signed [udv_pkg::VtxW-1:0] vertex_y;
  logic signed [udv_pkg::VtxW-1:0] vertex_z;
  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface udv_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [udv_pkg::DirW-1:0] dir_x;
  logic signed [udv_pkg::DirW-1:0] dir_y;
  logic signed [udv_pkg::DirW-1:0] dir_z;
  logic                            zero_length;
  modport source (output valid, dir_x, dir_y, dir_z, zero_length, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, zero_length, output ready);
endinterface

interface udv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [udv_pkg::CfgIdxW-1:0]  index;
  logic [udv_pkg::CfgW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/unit_direction_from_vertex.sv
// Unit direction from the source point to a vertex: top level and config registers.
// Takes one vertex per cycle while the output is not stalled and returns the unit
// vector from (source - detector) to it as three signed Q1.15 components, rounded
// to nearest with halves away from zero; a zero-length difference gives zeros and
// zero_length high. The pipeline has 3 front stages, 33 divider stages - one
// quotient bit each - 17 square root stages and the output register; throughput
// is one item per cycle when not stalled. Stalls back up stage by stage, so
// bubbles are squeezed out. Config writes are always taken and should only be
// issued while no item is in flight; indices above 5 are ignored.
module unit_direction_from_vertex (
  input  logic       clk_i,
  input  logic       rst_ni,
  udv_in_if.sink     in_if,
  udv_out_if.source  out_if,
  udv_cfg_if.sink    cfg_if
);
  import udv_pkg::*;

  udv_cfg_t  cfg_q;
  logic      front_v, front_r;
  udv_sum_t  front_d;
  logic      div_v, div_r;
  udv_quo_t  div_d;
  logic      sqrt_v, sqrt_r;
  udv_root_t sqrt_d;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SOURCE_X:   cfg_q.src[0] <= cfg_if.data;
        CFG_SOURCE_Y:   cfg_q.src[1] <= cfg_if.data;
        CFG_SOURCE_Z:   cfg_q.src[2] <= cfg_if.data;
        CFG_DETECTOR_X: cfg_q.det[0] <= cfg_if.data;
        CFG_DETECTOR_Y: cfg_q.det[1] <= cfg_if.data;
        CFG_DETECTOR_Z: cfg_q.det[2] <= cfg_if.data;
        default: ;
      endcase
    end
  end

  udv_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_if,
    .valid_o(front_v), .ready_i(front_r), .data_o(front_d)
  );

  udv_div u_div (
    .clk_i, .rst_ni,
    .valid_i(front_v), .ready_o(front_r), .data_i(front_d),
    .valid_o(div_v), .ready_i(div_r), .data_o(div_d)
  );

  udv_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i(div_v), .ready_o(div_r), .data_i(div_d),
    .valid_o(sqrt_v), .ready_i(sqrt_r), .data_o(sqrt_d)
  );

  udv_out u_out (
    .clk_i, .rst_ni,
    .valid_i(sqrt_v), .ready_o(sqrt_r), .data_i(sqrt_d), .out_if
  );

endmodule

// File: sv/udv_front.sv
// Front stages: difference vector, squares, sum of squares.
module udv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  udv_pkg::udv_cfg_t cfg_i,
  udv_in_if.sink            in_if,
  output logic              valid_o,
  input  logic              ready_i,
  output udv_pkg::udv_sum_t data_o
);
  import udv_pkg::*;

  localparam int unsigned N = 3;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;

  logic signed [DiffW-1:0] d_q [3];
  logic [SqW-1:0]          sq_q [3];
  logic [2:0]              neg_q;
  udv_sum_t                sum_q;

  logic signed [DiffW-1:0] d_d [3];
  logic [MagW-1:0]         mag [3];
  logic [SqW+1:0]          tot;

  always_comb begin
    rdy[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[0];
  assign valid_o     = v_q[N-1];
  assign data_o      = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_if.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // d = vertex - (source - detector), exact
  always_comb begin
    logic signed [VtxW-1:0] vtx [3];
    vtx[0] = in_if.vertex_x;
    vtx[1] = in_if.vertex_y;
    vtx[2] = in_if.vertex_z;
    for (int l = 0; l < 3; l++) begin
      d_d[l] = DiffW'(vtx[l]) - (DiffW'(signed'(cfg_i.src[l]))
                                 - DiffW'(signed'(cfg_i.det[l])));
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = d_q[l][DiffW-1] ? MagW'(-d_q[l]) : MagW'(d_q[l]);
    end
  end

  assign tot = (SqW+2)'(sq_q[0]) + (SqW+2)'(sq_q[1]) + (SqW+2)'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) d_q[l] <= d_d[l];
    end
    if (rdy[1]) begin
      for (int l = 0; l < 3; l++) begin
        sq_q[l]  <= SqW'(mag[l]) * SqW'(mag[l]);
        neg_q[l] <= d_q[l][DiffW-1];
      end
    end
    if (rdy[2]) begin
      sum_q.s    <= tot[SqW-1:0];
      for (int l = 0; l < 3; l++) sum_q.sq[l] <= sq_q[l];
      sum_q.neg  <= neg_q;
      sum_q.zero <= (tot == '0);
    end
  end

endmodule

// File: sv/udv_div.sv
// Restoring divider, one quotient bit per stage: floor(2^32 * d^2 / S).
module udv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  udv_pkg::udv_sum_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output udv_pkg::udv_quo_t data_o
);
  import udv_pkg::*;

  localparam int unsigned N = DivStages;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;

  logic [SqW-1:0]  s_q   [N];
  logic [SqW-1:0]  rem_q [N][3];
  logic [QuoW-1:0] quo_q [N][3];
  logic [2:0]      neg_q [N];
  logic            zero_q [N];

  always_comb begin
    rdy[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];

  always_comb begin
    for (int l = 0; l < 3; l++) data_o.quo[l] = quo_q[N-1][l];
    data_o.neg  = neg_q[N-1];
    data_o.zero = zero_q[N-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic [SqW-1:0]  s_in;
    logic [SqW:0]    rem_in [3];
    logic [QuoW-1:0] quo_in [3];
    logic [2:0]      neg_in;
    logic            zero_in;

    if (k == 0) begin : g_first
      // d^2 <= S, so the top quotient bit needs no shift
      always_comb begin
        s_in    = data_i.s;
        neg_in  = data_i.neg;
        zero_in = data_i.zero;
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = {1'b0, data_i.sq[l]};
          quo_in[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        s_in    = s_q[k-1];
        neg_in  = neg_q[k-1];
        zero_in = zero_q[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = {rem_q[k-1][l], 1'b0};
          quo_in[l] = quo_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        s_q[k]    <= s_in;
        neg_q[k]  <= neg_in;
        zero_q[k] <= zero_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= {1'b0, s_in}) begin
            rem_q[k][l] <= SqW'(rem_in[l] - {1'b0, s_in});
            quo_q[k][l] <= {quo_in[l][QuoW-2:0], 1'b1};
          end else begin
            rem_q[k][l] <= rem_in[l][SqW-1:0];
            quo_q[k][l] <= {quo_in[l][QuoW-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

// File: sv/udv_sqrt.sv
// Digit-by-digit integer square root, one root bit per stage.
module udv_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  udv_pkg::udv_quo_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output udv_pkg::udv_root_t data_o
);
  import udv_pkg::*;

  localparam int unsigned N = SqrtStages;
  localparam int unsigned RadW = 2 * N;
  localparam int unsigned TrialW = SqrtRemW + 2;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;

  logic [RadW-1:0]     rad_q  [N][3];
  logic [SqrtRemW-1:0] rem_q  [N][3];
  logic [RootW-1:0]    root_q [N][3];
  logic [2:0]          neg_q  [N];
  logic                zero_q [N];

  always_comb begin
    rdy[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];

  always_comb begin
    for (int l = 0; l < 3; l++) data_o.root[l] = root_q[N-1][l];
    data_o.neg  = neg_q[N-1];
    data_o.zero = zero_q[N-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stg
    localparam int unsigned P = N - 1 - k;  // radicand bit pair taken here
    logic [RadW-1:0]     rad_in  [3];
    logic [SqrtRemW-1:0] rem_in  [3];
    logic [RootW-1:0]    root_in [3];
    logic [2:0]          neg_in;
    logic                zero_in;
    logic [TrialW-1:0]   acc     [3];
    logic [TrialW-1:0]   trial   [3];

    if (k == 0) begin : g_first
      always_comb begin
        neg_in  = data_i.neg;
        zero_in = data_i.zero;
        for (int l = 0; l < 3; l++) begin
          rad_in[l]  = RadW'(data_i.quo[l]);
          rem_in[l]  = '0;
          root_in[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        neg_in  = neg_q[k-1];
        zero_in = zero_q[k-1];
        for (int l = 0; l < 3; l++) begin
          rad_in[l]  = rad_q[k-1][l];
          rem_in[l]  = rem_q[k-1][l];
          root_in[l] = root_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        acc[l]   = {rem_in[l], rad_in[l][2*P+1 -: 2]};
        trial[l] = {TrialW'(root_in[l]) << 2} | TrialW'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        neg_q[k]  <= neg_in;
        zero_q[k] <= zero_in;
        for (int l = 0; l < 3; l++) begin
          rad_q[k][l] <= rad_in[l];
          if (acc[l] >= trial[l]) begin
            rem_q[k][l]  <= SqrtRemW'(acc[l] - trial[l]);
            root_q[k][l] <= {root_in[l][RootW-2:0], 1'b1};
          end else begin
            rem_q[k][l]  <= SqrtRemW'(acc[l]);
            root_q[k][l] <= {root_in[l][RootW-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

// File: sv/udv_out.sv
// Output register: rounding from the root, sign, saturation, zero case.
module udv_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  udv_pkg::udv_root_t data_i,
  udv_out_if.source          out_if
);
  import udv_pkg::*;

  logic            v_q;
  logic [DirW-1:0] dir_q [3];
  logic            zero_q;
  logic [DirW-1:0] dir_d [3];
  logic [RootW:0]  inc   [3];
  logic [RootW-1:0] mag  [3];

  assign ready_o = !v_q || out_if.ready;

  // magnitude is the largest n with (2n-1)^2 <= quotient: (isqrt + 1) / 2
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      inc[l] = (RootW+1)'(data_i.root[l]) + (RootW+1)'(1);
      mag[l] = inc[l][RootW:1];
      if (data_i.zero) begin
        dir_d[l] = '0;
      end else if (data_i.neg[l]) begin
        dir_d[l] = DirW'(RootW'(0) - mag[l]);
      end else if (mag[l] > RootW'(DirMaxPos)) begin
        dir_d[l] = DirMaxPos;
      end else begin
        dir_d[l] = DirW'(mag[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      for (int l = 0; l < 3; l++) dir_q[l] <= dir_d[l];
      zero_q <= data_i.zero;
    end
  end

  assign out_if.valid       = v_q;
  assign out_if.dir_x       = signed'(dir_q[0]);
  assign out_if.dir_y       = signed'(dir_q[1]);
  assign out_if.dir_z       = signed'(dir_q[2]);
  assign out_if.zero_length = zero_q;

endmodule
